// ----- design/kpc_pkg.sv -----
`timescale 1ns / 1ps

package kpc_pkg;

    // default and ceiling for the number of keys
    localparam int NUM_KEYS_DEF = 5;
    localparam int NUM_KEYS_MAX = 16;

    // config register indexes
    localparam logic [2:0] CFG_KEY_ENABLE   = 3'd0;
    localparam logic [2:0] CFG_ACTIVE_LEVEL = 3'd1;
    localparam logic [2:0] CFG_DEBOUNCE     = 3'd2;
    localparam logic [2:0] CFG_LONG         = 3'd3;
    localparam logic [2:0] CFG_HOLD         = 3'd4;

    // config reset values
    localparam logic [7:0] DEBOUNCE_RST = 8'd4;
    localparam logic [8:0] LONG_RST     = 9'd200;
    localparam logic [8:0] HOLD_RST     = 9'd400;

    // per-key event codes
    typedef enum logic [2:0] {
        CODE_NONE     = 3'd0,
        CODE_DOWN     = 3'd1,
        CODE_LONG     = 3'd2,
        CODE_HOLD     = 3'd3,
        CODE_SHORT_UP = 3'd4,
        CODE_LONG_UP  = 3'd5,
        CODE_HOLD_UP  = 3'd6
    } t_key_code;

    // thresholds shared by every key
    typedef struct packed {
        logic [7:0] debounce_ticks;
        logic [8:0] long_ticks;
        logic [8:0] hold_ticks;
    } t_thresh;

endpackage

// ----- design/kpc_cfg_regs.sv -----
`timescale 1ns / 1ps

module kpc_cfg_regs #(
    parameter int NUM_KEYS = kpc_pkg::NUM_KEYS_DEF,
    parameter int CFG_DATA_W = (NUM_KEYS > 9) ? NUM_KEYS : 9
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [2:0]            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic [NUM_KEYS-1:0]   o_key_enable,
    output logic [NUM_KEYS-1:0]   o_active_level,
    output kpc_pkg::t_thresh      o_thresh
);

    logic [NUM_KEYS-1:0] r_key_enable;
    logic [NUM_KEYS-1:0] r_active_level;
    kpc_pkg::t_thresh    r_thresh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_enable              <= NUM_KEYS'(1);
            r_active_level            <= NUM_KEYS'(1);
            r_thresh.debounce_ticks   <= kpc_pkg::DEBOUNCE_RST;
            r_thresh.long_ticks       <= kpc_pkg::LONG_RST;
            r_thresh.hold_ticks       <= kpc_pkg::HOLD_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                kpc_pkg::CFG_KEY_ENABLE:   r_key_enable <= i_cfg_data[NUM_KEYS-1:0];
                kpc_pkg::CFG_ACTIVE_LEVEL: r_active_level <= i_cfg_data[NUM_KEYS-1:0];
                kpc_pkg::CFG_DEBOUNCE:     r_thresh.debounce_ticks <= i_cfg_data[7:0];
                kpc_pkg::CFG_LONG:         r_thresh.long_ticks <= i_cfg_data[8:0];
                kpc_pkg::CFG_HOLD:         r_thresh.hold_ticks <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    assign o_key_enable   = r_key_enable;
    assign o_active_level = r_active_level;
    assign o_thresh       = r_thresh;

endmodule

// ----- design/kpc_key_cell.sv -----
`timescale 1ns / 1ps

module kpc_key_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_advance,
    input  logic                i_enable,
    input  logic                i_active_level,
    input  logic                i_level,
    input  kpc_pkg::t_thresh    i_thresh,
    output kpc_pkg::t_key_code  o_code,
    output logic                o_pressed
);

    logic [8:0]         r_press;
    logic [7:0]         r_release;
    kpc_pkg::t_key_code r_code;

    logic [8:0]         n_press;
    logic [7:0]         n_release;
    kpc_pkg::t_key_code n_code;

    logic       w_active;
    logic [9:0] w_cnt;
    logic [9:0] w_deb;
    logic [9:0] w_long;
    logic [9:0] w_hold;
    logic [9:0] w_held;
    logic [7:0] w_rel;

    always_comb begin
        w_active  = (i_level == i_active_level);
        w_cnt     = {1'b0, r_press} + 10'd1;
        w_held    = {1'b0, r_press};
        w_deb     = {2'b00, i_thresh.debounce_ticks};
        w_long    = {1'b0, i_thresh.long_ticks};
        w_hold    = {1'b0, i_thresh.hold_ticks};
        w_rel     = (r_release == 8'hFF) ? r_release : r_release + 8'd1;
        n_press   = r_press;
        n_release = r_release;
        n_code    = r_code;
        if (i_enable) begin
            if (w_active) begin
                n_release = 8'd0;
                n_press   = w_cnt[8:0];
                if (w_cnt >= w_deb && w_cnt < w_long) begin
                    n_code = kpc_pkg::CODE_DOWN;
                end else if (w_cnt >= w_long && w_cnt < w_hold) begin
                    n_code = kpc_pkg::CODE_LONG;
                end else if (w_cnt >= w_hold) begin
                    n_code  = kpc_pkg::CODE_HOLD;
                    n_press = i_thresh.hold_ticks;
                end
            end else begin
                n_release = w_rel;
                if (w_rel >= i_thresh.debounce_ticks) begin
                    n_press = 9'd0;
                    if (w_held >= w_deb && w_held < w_long) begin
                        n_code = kpc_pkg::CODE_SHORT_UP;
                    end else if (w_held >= w_long && w_held < w_hold) begin
                        n_code = kpc_pkg::CODE_LONG_UP;
                    end else if (w_held >= w_hold) begin
                        n_code = kpc_pkg::CODE_HOLD_UP;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press   <= 9'd0;
            r_release <= 8'd0;
            r_code    <= kpc_pkg::CODE_NONE;
        end else if (i_advance) begin
            r_press   <= n_press;
            r_release <= n_release;
            r_code    <= n_code;
        end
    end

    // the word carries the code after this tick
    assign o_code    = n_code;
    assign o_pressed = i_enable && w_active;

endmodule

// ----- design/key_press_classifier_core.sv -----
`timescale 1ns / 1ps

// channel | direction | handshake                   | payload
// in      | input     | i_in_valid / o_in_stall     | i_key_levels
// out     | output    | o_out_valid / i_out_stall   | o_key_codes, o_any_pressed
// cfg     | input     | i_cfg_valid / o_cfg_ready   | i_cfg_index, i_cfg_data
//
// one word a cycle in and out unless the output stalls; results are registered
// the per-key counter update sits between input and result register
// reset is synchronous, active low: counters and codes clear, config to defaults
// an output stall holds the result word; the input stage still fills if empty
// config is always ready and must be written only while the block is idle

module key_press_classifier_core #(
    parameter int NUM_KEYS = kpc_pkg::NUM_KEYS_DEF,
    parameter int CFG_DATA_W = (NUM_KEYS > 9) ? NUM_KEYS : 9
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // scan tick words
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [NUM_KEYS-1:0]   i_key_levels,
    // result words
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [3*NUM_KEYS-1:0] o_key_codes,
    output logic                  o_any_pressed,
    // config writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [2:0]            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // input register
    logic                  r_in_valid;
    logic [NUM_KEYS-1:0]   r_levels;

    // result register
    logic                  r_out_valid;
    logic [3*NUM_KEYS-1:0] r_key_codes;
    logic                  r_any_pressed;

    logic                  w_out_free;
    logic                  w_advance;
    logic                  w_in_take;
    logic [NUM_KEYS-1:0]   w_key_enable;
    logic [NUM_KEYS-1:0]   w_active_level;
    kpc_pkg::t_thresh      w_thresh;
    logic [3*NUM_KEYS-1:0] w_codes;
    logic [NUM_KEYS-1:0]   w_pressed;

    // the result slot frees when empty or when its word is taken
    assign w_out_free = !r_out_valid || !i_out_stall;
    // held tick moves through the key cells into the result register
    assign w_advance  = r_in_valid && w_out_free;
    assign o_in_stall = r_in_valid && !w_out_free;
    assign w_in_take  = i_in_valid && !o_in_stall;

    assign o_cfg_ready = 1'b1;

    kpc_cfg_regs #(
        .NUM_KEYS   (NUM_KEYS),
        .CFG_DATA_W (CFG_DATA_W)
    ) u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_key_enable   (w_key_enable),
        .o_active_level (w_active_level),
        .o_thresh       (w_thresh)
    );

    // one cell per key, all updated side by side
    for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
        kpc_key_cell u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_advance      (w_advance),
            .i_enable       (w_key_enable[k]),
            .i_active_level (w_active_level[k]),
            .i_level        (r_levels[k]),
            .i_thresh       (w_thresh),
            .o_code         (w_codes[3*k +: 3]),
            .o_pressed      (w_pressed[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_take) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_levels <= i_key_levels;
        end
        if (w_advance) begin
            r_key_codes   <= w_codes;
            r_any_pressed <= |w_pressed;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_key_codes   = r_key_codes;
    assign o_any_pressed = r_any_pressed;

endmodule

// ----- design/kpc_checker.sv -----
`timescale 1ns / 1ps

module kpc_checker #(
    parameter int NUM_KEYS = kpc_pkg::NUM_KEYS_DEF
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_stall,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input logic [3*NUM_KEYS-1:0] o_key_codes,
    input logic                  o_any_pressed,
    input logic                  o_cfg_ready
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_key_codes) && $stable(o_any_pressed))
        else $error("stalled result word changed");

    // no result left over after reset
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // input backs up only behind a waiting result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled with free result slot");

    // an accepted word reaches the result register when the output is not stalled behind it
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) ##1 !i_out_stall |=> o_out_valid)
        else $error("accepted word lost");

    // config port never backs up
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("config port not ready");

endmodule

bind key_press_classifier_core kpc_checker #(
    .NUM_KEYS   (NUM_KEYS)
) u_kpc_checker (.*);

// ----- tb/sv/tb_key_press_classifier_core.sv -----
`timescale 1ns / 1ps

module tb_key_press_classifier_core;

    localparam int NKEYS     = kpc_pkg::NUM_KEYS_DEF;
    localparam int CODE_W    = 3 * NKEYS;
    localparam int CFG_W     = 9;
    // quiet cycles allowed before the run is declared hung
    localparam int HANG_LIMIT = 2000;

    // indexes past the last register, the block must ignore them
    localparam logic [2:0] CFG_SPARE_LO = 3'd5;
    localparam logic [2:0] CFG_SPARE_HI = 3'd7;

    // one expected result word
    typedef struct packed {
        logic [CODE_W-1:0] codes;
        logic              any;
    } t_scan_result;

    // clock, reset and every block input start at known values
    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_in_valid    = 1'b0;
    logic [NKEYS-1:0]  i_key_levels  = '0;
    logic              i_out_stall   = 1'b0;
    logic              i_cfg_valid   = 1'b0;
    logic [2:0]        i_cfg_index   = kpc_pkg::CFG_KEY_ENABLE;
    logic [CFG_W-1:0]  i_cfg_data    = '0;

    logic              o_in_stall;
    logic              o_out_valid;
    logic [CODE_W-1:0] o_key_codes;
    logic              o_any_pressed;
    logic              o_cfg_ready;

    key_press_classifier_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_key_levels  (i_key_levels),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_key_codes   (o_key_codes),
        .o_any_pressed (o_any_pressed),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor state: thresholds and per-key counters, as the block
    // should hold them after every accepted word
    // ------------------------------------------------------------------
    logic [NKEYS-1:0]   scan_mask;
    logic [NKEYS-1:0]   pressed_level;
    logic [7:0]         debounce_thr;
    logic [8:0]         long_thr;
    logic [8:0]         hold_thr;
    logic [8:0]         press_cnt   [NKEYS];
    logic [7:0]         release_cnt [NKEYS];
    kpc_pkg::t_key_code key_state   [NKEYS];

    // words waiting to be sent, and results waiting to come back
    logic [NKEYS-1:0] level_words [$];
    t_scan_result     result_store [$];

    int queued_words  = 0;
    int taken_words   = 0;
    int results_seen  = 0;
    int reg_writes    = 0;
    int mismatches    = 0;
    int code_changes [7];

    // idle percentages of sender and receiver, changed between phases
    int send_gap_pct   = 35;
    int recv_stall_pct = 87;

    logic         in_acc = 1'b0;
    int           quiet_cycles = 0;
    t_scan_result got_word;
    t_scan_result want_word;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    task automatic clear_keys();
        scan_mask     = NKEYS'(1);
        pressed_level = NKEYS'(1);
        debounce_thr  = kpc_pkg::DEBOUNCE_RST;
        long_thr      = kpc_pkg::LONG_RST;
        hold_thr      = kpc_pkg::HOLD_RST;
        for (int k = 0; k < NKEYS; k++) begin
            press_cnt[k]   = '0;
            release_cnt[k] = '0;
            key_state[k]   = kpc_pkg::CODE_NONE;
        end
        for (int c = 0; c < 7; c++) code_changes[c] = 0;
    endtask

    // one scan tick: update every enabled key and build the result word
    task automatic advance_keys(input logic [NKEYS-1:0] levels, output t_scan_result res);
        logic [9:0]         n;
        logic [8:0]         held;
        kpc_pkg::t_key_code next;
        res = '0;
        for (int k = 0; k < NKEYS; k++) begin
            next = key_state[k];
            if (scan_mask[k]) begin
                if (levels[k] == pressed_level[k]) begin
                    // key at its pressed level: count up, classify on the new count
                    n = {1'b0, press_cnt[k]} + 10'd1;
                    res.any = 1'b1;
                    release_cnt[k] = '0;
                    if (n >= debounce_thr && n < long_thr) begin
                        next = kpc_pkg::CODE_DOWN;
                    end else if (n >= long_thr && n < hold_thr) begin
                        next = kpc_pkg::CODE_LONG;
                    end else if (n >= hold_thr) begin
                        next = kpc_pkg::CODE_HOLD;
                        n = {1'b0, hold_thr};
                    end
                    press_cnt[k] = n[8:0];
                end else begin
                    // released: debounce the release, then classify the held count
                    held = press_cnt[k];
                    if (release_cnt[k] != 8'd255) release_cnt[k]++;
                    if (release_cnt[k] >= debounce_thr) begin
                        if (held >= debounce_thr && held < long_thr)
                            next = kpc_pkg::CODE_SHORT_UP;
                        else if (held >= long_thr && held < hold_thr)
                            next = kpc_pkg::CODE_LONG_UP;
                        else if (held >= hold_thr)
                            next = kpc_pkg::CODE_HOLD_UP;
                        press_cnt[k] = '0;
                    end
                end
            end
            if (next != key_state[k]) code_changes[next]++;
            key_state[k] = next;
            res.codes[3*k +: 3] = next;
        end
    endtask

    // ------------------------------------------------------------------
    // monitor: samples at the rising edge, tracks register writes,
    // predicts every accepted word and checks every result word
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        in_acc <= i_in_valid && !o_in_stall;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                reg_writes++;
                case (i_cfg_index)
                    kpc_pkg::CFG_KEY_ENABLE:   scan_mask     = i_cfg_data[NKEYS-1:0];
                    kpc_pkg::CFG_ACTIVE_LEVEL: pressed_level = i_cfg_data[NKEYS-1:0];
                    kpc_pkg::CFG_DEBOUNCE:     debounce_thr  = i_cfg_data[7:0];
                    kpc_pkg::CFG_LONG:         long_thr      = i_cfg_data[8:0];
                    kpc_pkg::CFG_HOLD:         hold_thr      = i_cfg_data[8:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !o_in_stall) begin
                advance_keys(i_key_levels, want_word);
                result_store.push_back(want_word);
                taken_words++;
            end
            if (o_out_valid && !i_out_stall) begin
                got_word = {o_key_codes, o_any_pressed};
                if (result_store.size() == 0) begin
                    report_mismatch("result word with none pending", 32'(got_word), 32'd0);
                end else begin
                    want_word = result_store.pop_front();
                    if (got_word.codes !== want_word.codes)
                        report_mismatch("key_codes", 32'(got_word.codes),
                                        32'(want_word.codes));
                    if (got_word.any !== want_word.any)
                        report_mismatch("any_pressed", 32'(got_word.any),
                                        32'(want_word.any));
                    results_seen++;
                end
            end
        end
    end

    // watchdog: any handshake on any channel resets the count
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                    || (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= HANG_LIMIT) begin
                $display("no handshake for %0d cycles, %0d results pending",
                         quiet_cycles, result_store.size());
                $display("FAIL");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // driver: changes inputs at the falling edge; a word is held until
    // the last rising edge took it, then the next one may follow a gap
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_in_valid || in_acc) begin
                if (level_words.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                    i_in_valid   <= 1'b1;
                    i_key_levels <= level_words.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic push_word(input logic [NKEYS-1:0] w);
        level_words.push_back(w);
        queued_words++;
    endtask

    // register write, only called while the block is idle
    task automatic write_reg(input logic [2:0] idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_thresholds(input logic [CFG_W-1:0] en, input logic [CFG_W-1:0] lvl,
                                  input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] lng,
                                  input logic [CFG_W-1:0] hld);
        write_reg(kpc_pkg::CFG_KEY_ENABLE, en);
        write_reg(kpc_pkg::CFG_ACTIVE_LEVEL, lvl);
        write_reg(kpc_pkg::CFG_DEBOUNCE, deb);
        write_reg(kpc_pkg::CFG_LONG, lng);
        write_reg(kpc_pkg::CFG_HOLD, hld);
    endtask

    // wait until every sent word has been answered, then let the pipe empty
    task automatic drain();
        while (taken_words != queued_words || result_store.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    function automatic int pick_run(input int max_run);
        // a quarter of the runs are short enough to be bounce
        if ($urandom_range(3) == 0) return $urandom_range(1, 3);
        return $urandom_range(1, max_run);
    endfunction

    // key levels held for random runs, with one-tick glitches and junk words mixed in
    task automatic queue_key_runs(input int count, input int max_run);
        logic [NKEYS-1:0] held;
        logic [NKEYS-1:0] w;
        int               left [NKEYS];
        int               roll;
        held = NKEYS'($urandom_range((1 << NKEYS) - 1));
        for (int k = 0; k < NKEYS; k++) left[k] = pick_run(max_run);
        for (int t = 0; t < count; t++) begin
            w = held;
            roll = $urandom_range(99);
            if (roll < 4) w = NKEYS'($urandom_range((1 << NKEYS) - 1));
            else if (roll < 14) w[$urandom_range(NKEYS - 1)] ^= 1'b1;
            push_word(w);
            for (int k = 0; k < NKEYS; k++) begin
                left[k]--;
                if (left[k] == 0) begin
                    held[k] = ~held[k];
                    left[k] = pick_run(max_run);
                end
            end
        end
    endtask

    initial begin
        clear_keys();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset thresholds, only key 0 scanned: a clean press to down,
        // a debounced release to short-up, then bounce and all-ones/all-zeros
        push_word(5'h00);
        push_word(5'h1F);
        push_word(5'h01);
        push_word(5'h01);
        push_word(5'h01);
        push_word(5'h1E);
        push_word(5'h00);
        push_word(5'h02);
        push_word(5'h1E);
        push_word(5'h15);
        push_word(5'h0A);
        push_word(5'h1F);
        push_word(5'h00);
        drain();

        // all keys, mixed polarity; enable data has bits above the mask,
        // and spare indexes must not disturb anything
        set_thresholds(9'h1FF, 9'h00A, 9'd2, 9'd6, 9'd10);
        write_reg(CFG_SPARE_LO, 9'h1FF);
        write_reg(CFG_SPARE_HI, 9'h000);
        queue_key_runs(300, 14);
        // sender holds off until every result is back, then carries on
        drain();
        queue_key_runs(100, 14);
        drain();

        // lowest thresholds: zero debounce accepts a release at once
        set_thresholds(9'h016, 9'h000, 9'd0, 9'd2, 9'd3);
        queue_key_runs(150, 6);
        drain();

        // sender now mostly idle, receiver mostly ready
        send_gap_pct   = 87;
        recv_stall_pct = 35;

        // highest thresholds: debounce data over 8 bits, release count saturates
        set_thresholds(9'h01F, 9'h01F, 9'h1FF, 9'd510, 9'd511);
        queue_key_runs(300, 300);
        drain();

        // long at or above hold: thresholds used as written
        set_thresholds(9'h00F, 9'h013, 9'd3, 9'd12, 9'd7);
        queue_key_runs(200, 16);
        drain();

        // no idling on either side
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        set_thresholds(9'h01F, 9'($urandom_range(31)), 9'd1, 9'd4, 9'd8);
        queue_key_runs(250, 12);
        drain();

        repeat (8) @(posedge i_clk);
        if (result_store.size() != 0)
            report_mismatch("result words never seen", 32'(result_store.size()), 32'd0);

        $display("checked %0d result words after %0d register writes, %0d mismatches",
                 results_seen, reg_writes, mismatches);
        $display("code changes: down %0d long %0d hold %0d short-up %0d long-up %0d hold-up %0d",
                 code_changes[kpc_pkg::CODE_DOWN], code_changes[kpc_pkg::CODE_LONG],
                 code_changes[kpc_pkg::CODE_HOLD], code_changes[kpc_pkg::CODE_SHORT_UP],
                 code_changes[kpc_pkg::CODE_LONG_UP], code_changes[kpc_pkg::CODE_HOLD_UP]);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
